/* hw/rtl/pmp_pkg.sv */
// ----------------------------------------------------------------------------
// pmp_pkg
// Shared widths, constants, stage enables and arithmetic helpers for the
// puck motion prediction step pipeline.
// ----------------------------------------------------------------------------
package pmp_pkg;

  // Field widths; all values are fixed point with 20 fraction bits.
  localparam int POS_W     = 32;
  localparam int ANG_W     = 23;
  localparam int DT_W      = 21;
  localparam int COEF_W    = 27;
  localparam int FRAC_W    = 20;
  localparam int CFG_IDX_W = 2;

  // Half of one output LSB, added before the right shift to round to nearest.
  localparam int RND_HALF = 1 << (FRAC_W - 1);

  // Angle constants in Q20.
  localparam logic signed [ANG_W:0] PI_Q     = 24'sd3294199;
  localparam logic signed [ANG_W:0] TWO_PI_Q = 24'sd6588397;

  // Magnitude of the angle sum before reduction and the matching 2*pi.
  localparam int                MAG_W      = 34;
  localparam logic [MAG_W-1:0]  TWO_PI_MAG = 34'd6588397;

  // Conditional subtract steps done in each reduction stage.
  localparam int RED_STEPS = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DAMPING  = 2'd0,
    CFG_FRICTION = 2'd1
  } cfg_idx_t;

  // Load enables of the last three pipeline stages.
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
  } pmp_stage_en_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [POS_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[POS_W-1:0];
    end
  endfunction

  // Restoring reduction of a magnitude by 2*pi: subtract 2*pi shifted left by
  // top, top-1, ... whenever it fits. Called with constant shift positions.
  function automatic logic [MAG_W-1:0] twopi_reduce(input logic [MAG_W-1:0] m,
                                                    input int unsigned top);
    logic [MAG_W-1:0] v;
    logic [MAG_W-1:0] d;
    v = m;
    for (int i = 0; i < RED_STEPS; i++) begin
      d = TWO_PI_MAG << (top - i);
      if (v >= d) begin
        v = v - d;
      end
    end
    return v;
  endfunction

endpackage

/* hw/rtl/pmp_if.sv */
// ----------------------------------------------------------------------------
// pmp_if
// Valid/ready channel interfaces: input state, predicted state and the
// configuration write channel.
// ----------------------------------------------------------------------------

// Input channel: current puck state and time step.
interface pmp_in_if import pmp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] vel_x;
  logic signed [POS_W-1:0] vel_y;
  logic signed [ANG_W-1:0] angle;
  logic signed [POS_W-1:0] spin_rate;
  logic        [DT_W-1:0]  step_time;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, angle, spin_rate,
                  step_time, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, angle, spin_rate,
                  step_time, output ready);
endinterface

// Result channel: predicted puck state.
interface pmp_out_if import pmp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] next_pos_x;
  logic signed [POS_W-1:0] next_pos_y;
  logic signed [POS_W-1:0] next_vel_x;
  logic signed [POS_W-1:0] next_vel_y;
  logic signed [ANG_W-1:0] next_angle;
  logic signed [POS_W-1:0] next_spin_rate;

  modport source (output valid, next_pos_x, next_pos_y, next_vel_x, next_vel_y,
                  next_angle, next_spin_rate, input ready);
  modport sink   (input valid, next_pos_x, next_pos_y, next_vel_x, next_vel_y,
                  next_angle, next_spin_rate, output ready);
endinterface

// Configuration write channel.
interface pmp_cfg_if import pmp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/pmp_angle_wrap.sv */
// ----------------------------------------------------------------------------
// pmp_angle_wrap
// Three-stage reduction of the advanced angle modulo 2*pi, followed by the
// wrap into [-pi, pi]. The remainder keeps the sign of the unreduced angle.
// ----------------------------------------------------------------------------
module pmp_angle_wrap import pmp_pkg::*; (
  input  logic                    clk,
  input  pmp_stage_en_t           en,
  input  logic [MAG_W-1:0]        a_abs,
  input  logic                    a_neg,
  output logic signed [ANG_W-1:0] angle_o
);

  logic [MAG_W-1:0]        s3_m_r;
  logic                    s3_neg_r;
  logic [MAG_W-1:0]        s4_m_r;
  logic                    s4_neg_r;
  logic [MAG_W-1:0]        m_fin;
  logic signed [ANG_W:0]   r_sgn;
  logic signed [ANG_W:0]   r_nxt;
  logic signed [ANG_W-1:0] angle_r;

  // Stages three and four: four quotient bits each, from the top down.
  always_ff @(posedge clk) begin
    if (en.s3) begin
      s3_m_r   <= twopi_reduce(a_abs, 3 * RED_STEPS - 1);
      s3_neg_r <= a_neg;
    end
    if (en.s4) begin
      s4_m_r   <= twopi_reduce(s3_m_r, 2 * RED_STEPS - 1);
      s4_neg_r <= s3_neg_r;
    end
  end

  // Last four quotient bits, restore the sign, then fold into [-pi, pi].
  always_comb begin
    m_fin = twopi_reduce(s4_m_r, RED_STEPS - 1);
    r_sgn = s4_neg_r ? -$signed({1'b0, m_fin[ANG_W-1:0]})
                     : $signed({1'b0, m_fin[ANG_W-1:0]});
    if (r_sgn > PI_Q) begin
      r_nxt = r_sgn - TWO_PI_Q;
    end else if (r_sgn < -PI_Q) begin
      r_nxt = r_sgn + TWO_PI_Q;
    end else begin
      r_nxt = r_sgn;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      angle_r <= r_nxt[ANG_W-1:0];
    end
  end

  assign angle_o = angle_r;

endmodule

/* hw/rtl/puck_motion_predict_step_core.sv */
// ----------------------------------------------------------------------------
// puck_motion_predict_step_core
// One-step puck motion predictor: position, damped and braked velocity,
// wrapped angle and spin rate, in a five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one puck state and a time step per transaction; out_ch
//   returns exactly one predicted state per input transaction, in order.
//   cfg_ch writes the damping (index 0) and friction (index 1) coefficients;
//   other indexes are ignored. It is always ready and should be written only
//   while the pipeline is empty.
//   A new transaction may enter every cycle while out_ch.ready stays high;
//   the pipeline has five register stages, each with its own valid bit
//   (multipliers, rounding and saturation, the split velocity multiply,
//   recombination and saturation of the velocity, and the output register),
//   with angle reduction by 2*pi in the last three, four quotient bits each.
//   When the receiver holds out_ch.ready low, the result stays in the output
//   register and earlier stages keep filling until every stage holds a
//   transaction; only then does in_ch.ready drop. Nothing is lost or repeated.
//   Synchronous reset empties the pipeline and clears both coefficients.
// ----------------------------------------------------------------------------
module puck_motion_predict_step_core import pmp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pmp_in_if.sink    in_ch,
  pmp_out_if.source out_ch,
  pmp_cfg_if.sink   cfg_ch
);

  // Configuration registers.
  logic [COEF_W-1:0] damp_r;
  logic [COEF_W-1:0] fric_r;

  // Stage valid bits and load enables.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;
  pmp_stage_en_t st_en;

  // Stage 1 registers.
  logic signed [POS_W-1:0] s1_px_r, s1_py_r, s1_vx_r, s1_vy_r, s1_spin_r;
  logic signed [ANG_W-1:0] s1_ang_r;
  logic [DT_W-1:0]         s1_dt_r;
  logic signed [53:0]      s1_pxp_r, s1_pyp_r, s1_spp_r;
  logic signed [59:0]      s1_dxp_r, s1_dyp_r;
  logic                    s1_fric_on_r;
  logic signed [53:0]      pxp_nxt, pyp_nxt, spp_nxt;
  logic signed [59:0]      dxp_nxt, dyp_nxt;
  logic                    fric_on_nxt;
  logic                    small_x, small_y;

  // Stage 2 registers.
  logic signed [POS_W-1:0] s2_npx_r, s2_npy_r, s2_vx_r, s2_vy_r, s2_spin_r;
  logic [DT_W-1:0]         s2_dt_r;
  logic signed [40:0]      s2_racx_r, s2_racy_r;
  logic [MAG_W-1:0]        s2_aabs_r;
  logic                    s2_aneg_r;
  logic signed [53:0]      px_rs, py_rs, sp_rs;
  logic signed [60:0]      fric_term, fx, fy, accx, accy, racx_nxt, racy_nxt;
  logic signed [63:0]      a_sum;
  logic [MAG_W-1:0]        aabs_nxt;

  // Stage 3 registers.
  logic signed [POS_W-1:0] s3_npx_r, s3_npy_r, s3_vx_r, s3_vy_r, s3_spin_r;
  logic signed [42:0]      s3_phx_r, s3_phy_r;
  logic [40:0]             s3_plx_r, s3_ply_r;

  // Stage 4 registers.
  logic signed [POS_W-1:0] s4_npx_r, s4_npy_r, s4_nvx_r, s4_nvy_r, s4_spin_r;
  logic signed [63:0]      dvx_full, dvy_full, dvx_rs, dvy_rs;

  // Stage 5, the output register.
  logic signed [POS_W-1:0] s5_npx_r, s5_npy_r, s5_nvx_r, s5_nvy_r, s5_spin_r;
  logic signed [ANG_W-1:0] angle_w;

  // Configuration writes; an unknown index is a no-op.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r <= '0;
      fric_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_DAMPING:  damp_r <= cfg_ch.data;
        CFG_FRICTION: fric_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its content moves on.
  assign en5         = !v5_r || out_ch.ready;
  assign en4         = !v4_r || en5;
  assign en3         = !v3_r || en4;
  assign en2         = !v2_r || en3;
  assign en1         = !v1_r || en2;
  assign in_ch.ready = en1;
  assign st_en       = '{s3: en3, s4: en4, s5: en5};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // Stage 1: all first-level products. The squared speed exceeds one LSB
  // unless both components lie in {-1, 0, 1} with at most one nonzero.
  assign pxp_nxt = $signed({1'b0, in_ch.step_time}) * in_ch.vel_x;
  assign pyp_nxt = $signed({1'b0, in_ch.step_time}) * in_ch.vel_y;
  assign spp_nxt = $signed({1'b0, in_ch.step_time}) * in_ch.spin_rate;
  assign dxp_nxt = $signed({1'b0, damp_r}) * in_ch.vel_x;
  assign dyp_nxt = $signed({1'b0, damp_r}) * in_ch.vel_y;
  assign small_x = (in_ch.vel_x == 32'sd0) || (in_ch.vel_x == 32'sd1) ||
                   (in_ch.vel_x == -32'sd1);
  assign small_y = (in_ch.vel_y == 32'sd0) || (in_ch.vel_y == 32'sd1) ||
                   (in_ch.vel_y == -32'sd1);
  assign fric_on_nxt = !(small_x && small_y) ||
                       ((in_ch.vel_x != 32'sd0) && (in_ch.vel_y != 32'sd0));

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_px_r      <= in_ch.pos_x;
      s1_py_r      <= in_ch.pos_y;
      s1_vx_r      <= in_ch.vel_x;
      s1_vy_r      <= in_ch.vel_y;
      s1_ang_r     <= in_ch.angle;
      s1_spin_r    <= in_ch.spin_rate;
      s1_dt_r      <= in_ch.step_time;
      s1_pxp_r     <= pxp_nxt;
      s1_pyp_r     <= pyp_nxt;
      s1_spp_r     <= spp_nxt;
      s1_dxp_r     <= dxp_nxt;
      s1_dyp_r     <= dyp_nxt;
      s1_fric_on_r <= fric_on_nxt;
    end
  end

  // Stage 2: round the products, finish positions, add friction to the
  // damping term and advance the angle.
  assign px_rs = (s1_pxp_r + 54'(RND_HALF)) >>> FRAC_W;
  assign py_rs = (s1_pyp_r + 54'(RND_HALF)) >>> FRAC_W;
  assign sp_rs = (s1_spp_r + 54'(RND_HALF)) >>> FRAC_W;

  assign fric_term = s1_fric_on_r ? 61'($signed({1'b0, fric_r, {FRAC_W{1'b0}}})) : '0;
  assign fx = (s1_vx_r > 32'sd0) ? fric_term :
              (s1_vx_r < 32'sd0) ? -fric_term : '0;
  assign fy = (s1_vy_r > 32'sd0) ? fric_term :
              (s1_vy_r < 32'sd0) ? -fric_term : '0;
  assign accx = 61'(s1_dxp_r) + fx;
  assign accy = 61'(s1_dyp_r) + fy;
  assign racx_nxt = (accx + 61'(RND_HALF)) >>> FRAC_W;
  assign racy_nxt = (accy + 61'(RND_HALF)) >>> FRAC_W;

  assign a_sum    = 64'(s1_ang_r) + 64'(sp_rs);
  assign aabs_nxt = a_sum[63] ? MAG_W'(-a_sum) : a_sum[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_npx_r  <= sat32(64'(s1_px_r) + 64'(px_rs));
      s2_npy_r  <= sat32(64'(s1_py_r) + 64'(py_rs));
      s2_vx_r   <= s1_vx_r;
      s2_vy_r   <= s1_vy_r;
      s2_spin_r <= s1_spin_r;
      s2_dt_r   <= s1_dt_r;
      s2_racx_r <= racx_nxt[40:0];
      s2_racy_r <= racy_nxt[40:0];
      s2_aabs_r <= aabs_nxt;
      s2_aneg_r <= a_sum[63];
    end
  end

  // Stage 3: step time times the rounded deceleration, as a signed high
  // part of 21 bits and an unsigned low part of 20 bits.
  always_ff @(posedge clk) begin
    if (en3) begin
      s3_npx_r  <= s2_npx_r;
      s3_npy_r  <= s2_npy_r;
      s3_vx_r   <= s2_vx_r;
      s3_vy_r   <= s2_vy_r;
      s3_spin_r <= s2_spin_r;
      s3_phx_r  <= $signed({1'b0, s2_dt_r}) * $signed(s2_racx_r[40:FRAC_W]);
      s3_phy_r  <= $signed({1'b0, s2_dt_r}) * $signed(s2_racy_r[40:FRAC_W]);
      s3_plx_r  <= s2_dt_r * s2_racx_r[FRAC_W-1:0];
      s3_ply_r  <= s2_dt_r * s2_racy_r[FRAC_W-1:0];
    end
  end

  // Stage 4: recombine the partial products, round, subtract and saturate.
  assign dvx_full = (64'(s3_phx_r) <<< FRAC_W) + $signed(64'(s3_plx_r));
  assign dvy_full = (64'(s3_phy_r) <<< FRAC_W) + $signed(64'(s3_ply_r));
  assign dvx_rs   = (dvx_full + 64'(RND_HALF)) >>> FRAC_W;
  assign dvy_rs   = (dvy_full + 64'(RND_HALF)) >>> FRAC_W;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_npx_r  <= s3_npx_r;
      s4_npy_r  <= s3_npy_r;
      s4_nvx_r  <= sat32(64'(s3_vx_r) - dvx_rs);
      s4_nvy_r  <= sat32(64'(s3_vy_r) - dvy_rs);
      s4_spin_r <= s3_spin_r;
    end
  end

  // Angle reduction runs alongside stages three to five.
  pmp_angle_wrap u_angle (
    .clk     (clk),
    .en      (st_en),
    .a_abs   (s2_aabs_r),
    .a_neg   (s2_aneg_r),
    .angle_o (angle_w)
  );

  // Stage 5: output register.
  always_ff @(posedge clk) begin
    if (en5) begin
      s5_npx_r  <= s4_npx_r;
      s5_npy_r  <= s4_npy_r;
      s5_nvx_r  <= s4_nvx_r;
      s5_nvy_r  <= s4_nvy_r;
      s5_spin_r <= s4_spin_r;
    end
  end

  assign out_ch.valid          = v5_r;
  assign out_ch.next_pos_x     = s5_npx_r;
  assign out_ch.next_pos_y     = s5_npy_r;
  assign out_ch.next_vel_x     = s5_nvx_r;
  assign out_ch.next_vel_y     = s5_nvy_r;
  assign out_ch.next_angle     = angle_w;
  assign out_ch.next_spin_rate = s5_spin_r;

  // An empty output register must never hold back the input side.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v5_r |-> in_ch.ready)
    else $error("input stalled while the output register is empty");

  // A transaction leaving stage four always lands in the output register.
  a_stage4_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && en5) |=> v5_r)
    else $error("transaction lost between stage four and the output");

  // Every delivered angle lies in [-pi, pi].
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> ((24'(out_ch.next_angle) <= PI_Q) && (24'(out_ch.next_angle) >= -PI_Q)))
    else $error("wrapped angle out of range");

endmodule
